// ===== sv/sem_pkg.sv =====
// Shared constants and controller/datapath interface types for the Sobel edge core.
`timescale 1ns / 1ps
package sem_pkg;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int CFG_W = 12;
	localparam int ROW_W = 12;
	localparam int SUM_W = 21;
	localparam int WIDTH_RESET = 640;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [SUM_W-1:0] SAT_SUM = 21'd64771;
	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic [1:0] rd_col;
		logic cap_en;
		logic [1:0] cap_col;
		logic grad;
		logic square;
		logic root_init;
		logic root_step;
		logic [2:0] root_bit;
		logic emit;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic need_emit;
		logic drain;
		logic out_free;
	} stat_t;
endpackage

// ===== sv/sobel_edge_magnitude_rgb_core.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude core for RGB pixels.
//
//  channel | direction | fields
//  s_axis  | in        | tdata: pixel_red, pixel_green, pixel_blue; tuser: drain
//  m_axis  | out       | tdata: edge_red, edge_green, edge_blue; tlast: last_of_frame
//  cfg     | in        | index 0 image_width, index 1 image_height
//
// A word that yields no result is only decided and, if it is a pixel, written to its row store.
// A word with a result also passes the three row-store reads, the gradient and square
// steps, the 8-step bit-serial square root and the rounding step before its write-back.
// Reset clears the position counters; row stores start undefined and are always
// written before any in-frame read. A stalled m_axis holds the result in its output
// register; the next word is accepted meanwhile and waits only at its own result.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_core #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [sem_pkg::PIX_W-1:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
	input  logic                      s_axis_tuser,  // drain
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [sem_pkg::PIX_W-1:0] m_axis_tdata,  // edge_red, edge_green, edge_blue
	output logic                      m_axis_tlast,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [sem_pkg::CFG_W-1:0] cfg_data
);
	import sem_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sem_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);
endmodule

// ===== sv/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/sem_datapath.sv =====
// Datapath: row stores, position counters, 3x3 window, gradients, square root, output word.
`timescale 1ns / 1ps
module sem_datapath #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sem_pkg::cmd_t             cmd,
	output sem_pkg::stat_t            stat,
	input  logic [sem_pkg::PIX_W-1:0] s_axis_tdata,
	input  logic                      s_axis_tuser,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [sem_pkg::CFG_W-1:0] cfg_data,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [sem_pkg::PIX_W-1:0] m_axis_tdata,
	output logic                      m_axis_tlast
);
	import sem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int WRST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	logic [WW-1:0]    width_q;
	logic [ROW_W-1:0] height_q;
	logic [ROW_W-1:0] rc_q, er_q;
	logic [CW-1:0]    cc_q, ec_q;
	logic [1:0]       rs_q, es_q;
	logic [PIX_W-1:0] pix_q;
	logic             drain_q;

	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] rd [3];
	logic [1:0]       slot [3];

	logic signed [10:0] gx_s1 [3];
	logic signed [10:0] gy_s1 [3];
	logic [SUM_W-1:0]   sum_s2 [3];
	logic [CH_W-1:0]    q_q [3];

	function automatic logic [1:0] next3(input logic [1:0] s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic logic signed [10:0] kern(input logic [7:0] a0, input logic [7:0] a1,
			input logic [7:0] a2, input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		logic [9:0] pos;
		logic [9:0] neg;
		pos = {2'b0, b0} + {1'b0, b1, 1'b0} + {2'b0, b2};
		neg = {2'b0, a0} + {1'b0, a1, 1'b0} + {2'b0, a2};
		return $signed({1'b0, pos}) - $signed({1'b0, neg});
	endfunction

	// status
	logic restart_in;
	logic cc_wrap, ec_wrap;
	assign restart_in = cmd.load && !s_axis_tuser && (rc_q >= height_q);
	assign cc_wrap = (32'(cc_q) + 32'd1) >= 32'(width_q);
	assign ec_wrap = (32'(ec_q) + 32'd1) >= 32'(width_q);

	always_comb begin
		if (drain_q) begin
			stat.need_emit = (rc_q >= height_q) && (er_q < height_q);
		end else begin
			stat.need_emit = ({1'b0, rc_q} >= ({1'b0, er_q} + 13'd2)) ||
				(({1'b0, rc_q} == ({1'b0, er_q} + 13'd1)) && (cc_q > ec_q));
		end
		stat.drain = drain_q;
		stat.out_free = !m_axis_tvalid || m_axis_tready;
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(WRST);
			height_q <= HEIGHT_RESET;
			rc_q <= '0;
			er_q <= '0;
			cc_q <= '0;
			ec_q <= '0;
			rs_q <= '0;
			es_q <= '0;
		end else if (cfg_we || restart_in) begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH: begin
						if (cfg_data[10:0] == 11'd0) begin
							width_q <= WW'(1);
						end else if (32'(cfg_data[10:0]) > 32'(MAX_WIDTH)) begin
							width_q <= WW'(MAX_WIDTH);
						end else begin
							width_q <= WW'(cfg_data[10:0]);
						end
					end
					REG_HEIGHT: begin
						height_q <= (cfg_data == '0) ? ROW_W'(1) : cfg_data;
					end
				endcase
			end
			rc_q <= '0;
			er_q <= '0;
			cc_q <= '0;
			ec_q <= '0;
			rs_q <= '0;
			es_q <= '0;
		end else begin
			if (cmd.write) begin
				if (cc_wrap) begin
					cc_q <= '0;
					rc_q <= rc_q + ROW_W'(1);
					rs_q <= next3(rs_q);
				end else begin
					cc_q <= cc_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				if (ec_wrap) begin
					ec_q <= '0;
					er_q <= er_q + ROW_W'(1);
					es_q <= next3(es_q);
				end else begin
					ec_q <= ec_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= s_axis_tdata;
			drain_q <= s_axis_tuser;
		end
	end

	// row stores, one per row slot
	logic [CW-1:0] raddr;
	assign raddr = CW'(32'(ec_q) + 32'(cmd.rd_col) - 32'd1);

	for (genvar k = 0; k < 3; k++) begin : g_row
		sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
			.clk   (clk),
			.we    (cmd.write && (rs_q == 2'(k))),
			.waddr (cc_q),
			.wdata (pix_q),
			.re    (cmd.rd_en),
			.raddr (raddr),
			.rdata (rd[k])
		);
	end

	assign slot[1] = es_q;
	assign slot[2] = next3(es_q);
	assign slot[0] = next3(next3(es_q));

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][cmd.cap_col] <= rd[slot[i]];
			end
		end
	end

	// masked window: out-of-frame neighbours are zero, the incoming pixel is not stored yet
	logic rv0, rv2, cv0, cv2, ovr;
	logic [PIX_W-1:0] v [3][3];
	assign rv0 = er_q != '0;
	assign rv2 = ({1'b0, er_q} + 13'd1) < {1'b0, height_q};
	assign cv0 = ec_q != '0;
	assign cv2 = (32'(ec_q) + 32'd1) < 32'(width_q);
	assign ovr = !drain_q && ({1'b0, rc_q} == ({1'b0, er_q} + 13'd1)) &&
		(32'(cc_q) == (32'(ec_q) + 32'd1));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				v[i][j] = win_q[i][j];
				if ((i == 0 && !rv0) || (i == 2 && !rv2) || (j == 0 && !cv0) ||
						(j == 2 && !cv2)) begin
					v[i][j] = '0;
				end else if (i == 2 && j == 2 && ovr) begin
					v[i][j] = pix_q;
				end
			end
		end
	end

	// per-channel gradient, energy and square root
	logic [CH_W-1:0] res [3];
	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		logic signed [21:0] px, py;
		logic [CH_W-1:0]    t;
		logic [15:0]        tt;
		logic [16:0]        qq;
		assign px = gx_s1[ch] * gx_s1[ch];
		assign py = gy_s1[ch] * gy_s1[ch];
		assign t = q_q[ch] | (CH_W'(1) << cmd.root_bit);
		assign tt = {8'b0, t} * {8'b0, t};
		assign qq = 17'({8'b0, q_q[ch]} * {8'b0, q_q[ch]}) + 17'(q_q[ch]);

		always_ff @(posedge clk) begin
			if (cmd.grad) begin
				gx_s1[ch] <= kern(v[0][0][ch*CH_W +: CH_W], v[1][0][ch*CH_W +: CH_W],
					v[2][0][ch*CH_W +: CH_W], v[0][2][ch*CH_W +: CH_W],
					v[1][2][ch*CH_W +: CH_W], v[2][2][ch*CH_W +: CH_W]);
				gy_s1[ch] <= kern(v[0][0][ch*CH_W +: CH_W], v[0][1][ch*CH_W +: CH_W],
					v[0][2][ch*CH_W +: CH_W], v[2][0][ch*CH_W +: CH_W],
					v[2][1][ch*CH_W +: CH_W], v[2][2][ch*CH_W +: CH_W]);
			end
			if (cmd.square) begin
				sum_s2[ch] <= px[SUM_W-1:0] + py[SUM_W-1:0];
			end
			if (cmd.root_init) begin
				q_q[ch] <= '0;
			end else if (cmd.root_step && (SUM_W'(tt) <= sum_s2[ch])) begin
				q_q[ch] <= t;
			end
		end

		always_comb begin
			if (sum_s2[ch] >= SAT_SUM) begin
				res[ch] = 8'd255;
			end else if (sum_s2[ch] > SUM_W'(qq)) begin
				res[ch] = q_q[ch] + 8'd1;
			end else begin
				res[ch] = q_q[ch];
			end
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_axis_tdata <= {res[2], res[1], res[0]};
			m_axis_tlast <= (({1'b0, er_q} + 13'd1) == {1'b0, height_q}) && ec_wrap;
		end
	end
endmodule

// ===== sv/sem_ctrl.sv =====
// Controller: sequences accept, window read, gradient, square root and write-back.
`timescale 1ns / 1ps
module sem_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  sem_pkg::stat_t stat,
	output sem_pkg::cmd_t  cmd
);
	import sem_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECIDE = 4'd1;
	localparam logic [3:0] S_READ   = 4'd2;
	localparam logic [3:0] S_CAP    = 4'd3;
	localparam logic [3:0] S_GRAD   = 4'd4;
	localparam logic [3:0] S_SQR    = 4'd5;
	localparam logic [3:0] S_ROOT   = 4'd6;
	localparam logic [3:0] S_ROUND  = 4'd7;
	localparam logic [3:0] S_WRITE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	assign s_axis_tready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.rd_col = cnt_q[1:0];
		cmd.cap_col = cnt_q[1:0] - 2'd1;
		cmd.root_bit = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = s_axis_tvalid;
				if (s_axis_tvalid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cnt_d = '0;
				priority if (stat.need_emit) begin
					state_d = S_READ;
				end else if (!stat.drain) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				cmd.cap_en = cnt_q != '0;
				if (cnt_q == 3'd2) begin
					state_d = S_CAP;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			S_CAP: begin
				cmd.cap_en = 1'b1;
				cmd.cap_col = 2'd2;
				state_d = S_GRAD;
			end
			S_GRAD: begin
				cmd.grad = 1'b1;
				state_d = S_SQR;
			end
			S_SQR: begin
				cmd.square = 1'b1;
				cmd.root_init = 1'b1;
				cnt_d = 3'd7;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_ROUND;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			S_ROUND: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = stat.drain ? S_IDLE : S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end
endmodule

// ===== verif/sobel_edge_magnitude_rgb_core_test.sv =====
// Self-checking testbench for the streaming RGB Sobel edge magnitude core.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_core_test;
	import sem_pkg::*;

	localparam int MAXW = 1024;
	localparam logic [20:0] SUM_LIMIT = 21'd64771;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} edge_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [PIX_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [PIX_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sobel_edge_magnitude_rgb_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0] rows [3][MAXW][3];
	int unsigned frame_w, frame_h, in_row, in_col, out_row, out_col;
	edge_t expected_edges[$];
	int errors;
	bit stall_on;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int pixel_at(int r, int c, int ch, logic [7:0] px[3], int pr, int pc,
		bit use_px);
		if (r < 0 || c < 0 || r >= frame_h || c >= frame_w) return 0;
		if (use_px && r == pr && c == pc) return px[ch];
		return rows[r % 3][c][ch];
	endfunction

	function automatic logic [7:0] rounded_root(logic [20:0] s);
		logic [8:0] q;
		logic [8:0] t;
		q = '0;
		if (s >= SUM_LIMIT) return 8'd255;
		for (int b = 7; b >= 0; b--) begin
			t = q | (9'd1 << b);
			if (t * t <= s) q = t;
		end
		if (s > q * q + q) q++;
		return q > 255 ? 8'd255 : q[7:0];
	endfunction

	function automatic void push_edge(logic [7:0] px[3], int pr, int pc, bit use_px);
		int gx, gy, v, s;
		logic [7:0] mag[3];
		edge_t e;
		int kx[3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
		int ky[3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
		for (int ch = 0; ch < 3; ch++) begin
			gx = 0;
			gy = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					v = pixel_at(out_row + i - 1, out_col + j - 1, ch, px, pr, pc, use_px);
					gx += v * kx[i][j];
					gy += v * ky[i][j];
				end
			s = gx * gx + gy * gy;
			mag[ch] = rounded_root(s[20:0]);
		end
		e.red = mag[0];
		e.green = mag[1];
		e.blue = mag[2];
		e.last = (out_row == frame_h - 1 && out_col == frame_w - 1);
		expected_edges.push_back(e);
		out_col++;
		if (out_col >= frame_w) begin
			out_col = 0;
			out_row++;
		end
	endfunction

	function automatic void predict_word(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit drain);
		logic [7:0] px[3];
		if (drain) begin
			if (in_row >= frame_h && out_row < frame_h) push_edge(px, -1, -1, 1'b0);
			return;
		end
		if (in_row >= frame_h) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		end
		px[0] = r; px[1] = g; px[2] = b;
		if (in_row >= out_row + 2 || (in_row == out_row + 1 && in_col > out_col))
			push_edge(px, in_row, in_col, 1'b1);
		for (int ch = 0; ch < 3; ch++) rows[in_row % 3][in_col][ch] = px[ch];
		in_col++;
		if (in_col >= frame_w) begin
			in_col = 0;
			in_row++;
		end
	endfunction

	function automatic bit idle_now();
		return !stall_on && ($urandom_range(99) < 31);
	endfunction

	// valid stays high after a word; an idle gap or wait_drained drops it
	task automatic send_word(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit drain);
		if (idle_now()) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
			while (idle_now()) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {b, g, r};
		s_axis_tuser <= drain;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_word(r, g, b, drain);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		s_axis_tvalid <= 0;
		while (expected_edges.size() != 0) @(negedge clk);
		while (n < 40) begin
			@(negedge clk);
			n++;
		end
	endtask

	task automatic write_reg(logic [0:0] idx, int value);
		wait_drained();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_WIDTH) begin
			frame_w = value[10:0] == 0 ? 1 : (value[10:0] > MAXW ? MAXW : value[10:0]);
		end else begin
			frame_h = value[11:0] == 0 ? 1 : value[11:0];
		end
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
	endtask

	task automatic send_frame(int kind, int drains);
		logic [7:0] r, g, b;
		for (int i = 0; i < frame_w * frame_h; i++) begin
			case (kind)
				0: begin r = 8'hFF; g = 8'hFF; b = 8'hFF; end
				1: begin r = 8'h00; g = 8'h00; b = 8'h00; end
				2: begin
					r = i[0] ? 8'hFF : 8'h00;
					g = i[1] ? 8'hFF : 8'h00;
					b = 8'hFF - r;
				end
				default: begin
					r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
					if ($urandom_range(3) == 0) r = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
				end
			endcase
			send_word(r, g, b, 1'b0);
		end
		for (int i = 0; i < drains; i++) send_word(8'h00, 8'h00, 8'h00, 1'b1);
	endtask

	task automatic test_directed();
		write_reg(REG_WIDTH, 4);
		write_reg(REG_HEIGHT, 3);
		send_word(8'h12, 8'h34, 8'h56, 1'b1);
		send_frame(0, 5);
		send_frame(2, 7);
		send_frame(1, 2);
		send_word(8'hAA, 8'h55, 8'hFF, 1'b0);
	endtask

	task automatic test_extreme_sizes();
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 0);
		send_frame(3, 3);
		write_reg(REG_WIDTH, 1);
		write_reg(REG_HEIGHT, 5);
		send_frame(3, 2);
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 1);
		send_frame(0, 4);
		write_reg(REG_WIDTH, 2);
		write_reg(REG_HEIGHT, 12'hFFF);
		for (int i = 0; i < 40; i++)
			send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
	endtask

	task automatic test_random_frames();
		int w, h;
		write_reg(REG_WIDTH, 8);
		for (int f = 0; f < 24; f++) begin
			w = $urandom_range(12, 1);
			h = $urandom_range(8, 1);
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			stall_on = (f >= 8 && f < 12);
			send_frame(3, w + 1 + ($urandom_range(3) == 0 ? $urandom_range(3) : 0));
			if ($urandom_range(4) == 0) send_frame(3, $urandom_range(w));
		end
		stall_on = 0;
	endtask

	always @(posedge clk) begin
		edge_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_edges.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				e = expected_edges.pop_front();
				if (m_axis_tdata[7:0] !== e.red) begin
					$error("edge_red exp %0d got %0d", e.red, m_axis_tdata[7:0]); errors++;
				end
				if (m_axis_tdata[15:8] !== e.green) begin
					$error("edge_green exp %0d got %0d", e.green, m_axis_tdata[15:8]); errors++;
				end
				if (m_axis_tdata[23:16] !== e.blue) begin
					$error("edge_blue exp %0d got %0d", e.blue, m_axis_tdata[23:16]); errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_of_frame exp %0d got %0d", e.last, m_axis_tlast); errors++;
				end
			end
		end
	end

	always @(negedge clk) m_axis_tready <= stall_on ? 1'b1 : ($urandom_range(99) >= 31);

	initial begin
		#20ms;
		$display("** sobel_edge_magnitude_rgb_core: FAILED **");
		$finish;
	end

	initial begin
		errors = 0;
		stall_on = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_index = REG_WIDTH;
		cfg_data = 0;
		frame_w = 640; frame_h = 480;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_extreme_sizes();
		test_random_frames();
		wait_drained();
		if (errors == 0 && expected_edges.size() == 0)
			$display("** sobel_edge_magnitude_rgb_core: PASSED **");
		else
			$display("** sobel_edge_magnitude_rgb_core: FAILED **");
		$finish;
	end
endmodule
